FILE: design/tkai_pkg.sv
// ============================================================================
// tkai_pkg: shared types and constants for the top-k average insertion list
// Holds the beat layouts of both channels, field widths, slot-count
// derived widths and operation codes.
// ============================================================================
package tkai_pkg;

    localparam int TOP_N   = 16;
    localparam int KEY_W   = 64;
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 19;
    localparam int SIDX_W  = 4;
    localparam int PROD_W  = TOTAL_W + COUNT_W;

    // slot position and walk counter widths (walk counter must reach TOP_N)
    localparam int IDX_W  = (TOP_N > 1) ? $clog2(TOP_N) : 1;
    localparam int WALK_W = $clog2(TOP_N + 1);
    // common width for range checks of the read index
    localparam int RANGE_W = 9;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic               op;
        logic [KEY_W-1:0]   entry_key;
        logic [COUNT_W-1:0] entry_count;
        logic [TOTAL_W-1:0] entry_total;
        logic [SIDX_W-1:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0]   slot_key;
        logic [COUNT_W-1:0] slot_count;
        logic [TOTAL_W-1:0] slot_total;
        logic               slot_used;
    } rsp_t;

endpackage

FILE: design/tkai_mul.sv
// ============================================================================
// tkai_mul: shared registered multiplier
// Multiplies a star total by a review count; the product is registered
// when enabled and held otherwise.
// ============================================================================
module tkai_mul
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [tkai_pkg::TOTAL_W-1:0]  a,
    input  logic [tkai_pkg::COUNT_W-1:0]  b,
    output logic [tkai_pkg::PROD_W-1:0]   product
);

    logic [tkai_pkg::PROD_W-1:0] product_reg;
    logic [tkai_pkg::PROD_W-1:0] product_next;

    assign product_next = tkai_pkg::PROD_W'(a) * tkai_pkg::PROD_W'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

FILE: design/top_k_average_insert_top.sv
// ============================================================================
// top_k_average_insert_top: top-k list ordered by average rating
// Keeps TOP_N slots in ascending order of total/count, slot 0 lowest, and
// walks insert candidates upward through them with one shared multiplier.
// ============================================================================
//
// Usage:
//   The request channel (req_valid / req_stall / req_data) carries one beat
//   per operation. An insert beat walks its candidate upward from slot 0;
//   a read beat returns the contents of slot_index on the response channel
//   (rsp_valid / rsp_stall / rsp_data). Inserts produce no response beat.
//   A read answers in the cycle after it is taken. An insert occupies
//   the block through a MINE and a THEIRS phase per visited slot plus a
//   final decision phase, up to all TOP_N slots; an insert with a zero
//   count finishes in the cycle it is taken. The single multiplier
//   forms the two cross products of each slot in turn; the decision for
//   a slot overlaps the first product of the next slot.
//   Reset empties every slot (key, count and total zero) and drops any
//   pending response. While the receiver stalls, the response beat holds
//   in its output register and every request beat, insert or read, is
//   stalled; a new request is taken in the same cycle the held beat leaves.
//
module top_k_average_insert_top
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  tkai_pkg::req_t   req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output tkai_pkg::rsp_t   rsp_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MINE   = 2'd1;  // candidate total x slot count
    localparam logic [1:0] ST_THEIRS = 2'd2;  // slot total x candidate count

    localparam int N     = tkai_pkg::TOP_N;
    localparam int IW    = tkai_pkg::IDX_W;
    localparam int WW    = tkai_pkg::WALK_W;

    // slot storage
    logic [tkai_pkg::KEY_W-1:0]   key_reg   [N];
    logic [tkai_pkg::COUNT_W-1:0] count_reg [N];
    logic [tkai_pkg::TOTAL_W-1:0] total_reg [N];

    // sequencer
    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [WW-1:0] walk_reg;
    logic [WW-1:0] walk_next;

    // candidate under insertion
    logic [tkai_pkg::KEY_W-1:0]   cand_key_reg;
    logic [tkai_pkg::COUNT_W-1:0] cand_count_reg;
    logic [tkai_pkg::TOTAL_W-1:0] cand_total_reg;

    logic [tkai_pkg::PROD_W-1:0] mine_reg;
    logic [tkai_pkg::PROD_W-1:0] product;

    logic           rsp_valid_reg;
    tkai_pkg::rsp_t rsp_data_reg;

    logic req_take;
    logic rsp_take;
    logic take_read;
    logic take_insert;

    // multiplier operand selection
    logic [IW-1:0]                mul_pos;
    logic                         mul_en;
    logic [tkai_pkg::TOTAL_W-1:0] mul_a;
    logic [tkai_pkg::COUNT_W-1:0] mul_b;

    // decision on the slot below the walk position
    logic [WW-1:0]                dec_wide;
    logic [IW-1:0]                dec_pos;
    logic                         deciding;
    logic [tkai_pkg::KEY_W-1:0]   dec_key;
    logic [tkai_pkg::COUNT_W-1:0] dec_count;
    logic [tkai_pkg::TOTAL_W-1:0] dec_total;
    logic                         dec_empty;
    logic                         dec_same;
    logic                         dec_higher;
    logic                         do_shift;
    logic                         do_over;
    logic                         do_stop;

    // read path
    logic [IW-1:0] rd_pos;
    logic          rd_in_range;

    // ------------------------------------------------------------------
    // Handshakes: take requests only when idle and the response register
    // is free or draining this cycle.
    // ------------------------------------------------------------------
    assign rsp_take    = rsp_valid_reg && !rsp_stall;
    assign req_stall   = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign req_take    = req_valid && !req_stall;
    assign take_read   = req_take && (req_data.op == tkai_pkg::OP_READ);
    assign take_insert = req_take && (req_data.op == tkai_pkg::OP_INSERT)
                         && (req_data.entry_count != '0);

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // ------------------------------------------------------------------
    // Decision for slot walk-1, made in the MINE phase of the next slot.
    // Slot walk-1 only touches itself and the slot below, so the products
    // already formed for slot walk stay valid.
    // ------------------------------------------------------------------
    assign dec_wide   = walk_reg - WW'(1);
    assign dec_pos    = dec_wide[IW-1:0];
    assign deciding   = (state_reg == ST_MINE) && (walk_reg != '0);
    assign dec_key    = key_reg[dec_pos];
    assign dec_count  = count_reg[dec_pos];
    assign dec_total  = total_reg[dec_pos];
    assign dec_empty  = (dec_count == '0);
    assign dec_same   = (dec_key == cand_key_reg);
    assign dec_higher = (mine_reg > product);

    assign do_shift = deciding && (dec_empty || (!dec_same && dec_higher));
    assign do_over  = deciding && !dec_empty && dec_same;
    assign do_stop  = deciding && !do_shift && !do_over;

    // ------------------------------------------------------------------
    // Shared multiplier: MINE forms cand_total*count[walk], THEIRS forms
    // total[walk]*cand_count.
    // ------------------------------------------------------------------
    assign mul_pos = walk_reg[IW-1:0];

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = cand_total_reg;
        mul_b  = cand_count_reg;
        if (state_reg == ST_MINE)
        begin
            mul_en = (walk_reg != WW'(N));
            mul_a  = cand_total_reg;
            mul_b  = count_reg[mul_pos];
        end
        else if (state_reg == ST_THEIRS)
        begin
            mul_en = 1'b1;
            mul_a  = total_reg[mul_pos];
            mul_b  = cand_count_reg;
        end
    end

    tkai_mul u_mul
    (
        .clk     (clk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        walk_next  = walk_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_insert)
                begin
                    state_next = ST_MINE;
                    walk_next  = '0;
                end
            end
            ST_MINE:
            begin
                // stop on a higher or equal slot, or after the top slot
                if (do_stop || (walk_reg == WW'(N)))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_THEIRS;
                end
            end
            ST_THEIRS:
            begin
                state_next = ST_MINE;
                walk_next  = walk_reg + WW'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

    // hold the first cross product while the second one is formed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_THEIRS)
        begin
            mine_reg <= product;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_insert)
        begin
            cand_key_reg   <= req_data.entry_key;
            cand_count_reg <= req_data.entry_count;
            cand_total_reg <= req_data.entry_total;
        end
    end

    // ------------------------------------------------------------------
    // Slot updates: a shift moves the decided slot down one place (slot 0
    // drops out) and puts the candidate in its place; a key match
    // overwrites count and total in place.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                key_reg[i]   <= '0;
                count_reg[i] <= '0;
                total_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (do_shift && (dec_wide == WW'(i)))
                begin
                    key_reg[i]   <= cand_key_reg;
                    count_reg[i] <= cand_count_reg;
                    total_reg[i] <= cand_total_reg;
                end
                else if (do_shift && (dec_wide == WW'(i + 1)))
                begin
                    key_reg[i]   <= dec_key;
                    count_reg[i] <= dec_count;
                    total_reg[i] <= dec_total;
                end
                else if (do_over && (dec_wide == WW'(i)))
                begin
                    count_reg[i] <= cand_count_reg;
                    total_reg[i] <= cand_total_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Read path: out-of-range slots answer all zero.
    // ------------------------------------------------------------------
    assign rd_pos      = IW'(req_data.slot_index);
    assign rd_in_range = (tkai_pkg::RANGE_W'(req_data.slot_index)
                          < tkai_pkg::RANGE_W'(N));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (take_read)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_take)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_read)
        begin
            if (rd_in_range)
            begin
                rsp_data_reg.slot_key   <= key_reg[rd_pos];
                rsp_data_reg.slot_count <= count_reg[rd_pos];
                rsp_data_reg.slot_total <= total_reg[rd_pos];
                rsp_data_reg.slot_used  <= (count_reg[rd_pos] != '0);
            end
            else
            begin
                rsp_data_reg <= '0;
            end
        end
    end

endmodule

FILE: sim/tkai_list_checker.sv
// ============================================================================
// tkai_list_checker: prediction and comparison for the top-k rating list
// Watches both channels of the block. Each insert beat taken is walked
// through a private copy of the slot list. Each read beat queues the slot
// contents it should return. Response beats are checked against that queue
// in order.
// ============================================================================
module tkai_list_checker
    import tkai_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp_data,
    output int   fail_count,
    output int   reads_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 20;

    // private copy of the slot list, slot 0 lowest average
    logic [KEY_W-1:0]   list_key [TOP_N];
    logic [COUNT_W-1:0] list_cnt [TOP_N];
    logic [TOTAL_W-1:0] list_tot [TOP_N];

    rsp_t read_queue[$];
    int   fail_tally = 0;

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        if (fail_tally < MAX_PRINTED)
            $display("%0t ns: %s mismatch, got %h want %h", $realtime, what, got, want);
        fail_tally++;
    endtask

    // walk a candidate upward from slot 0; lower or empty slots shift down
    task automatic walk_candidate(input req_t cand);
        logic [PROD_W-1:0] mine;
        logic [PROD_W-1:0] theirs;
        logic              move_down;
        if (cand.entry_count == '0)
            return;
        for (int i = 0; i < TOP_N; i++)
        begin
            if (list_cnt[i] == '0)
                move_down = 1'b1;
            else if (list_key[i] == cand.entry_key)
            begin
                // same key: overwrite in place and keep walking
                list_cnt[i] = cand.entry_count;
                list_tot[i] = cand.entry_total;
                continue;
            end
            else
            begin
                mine      = PROD_W'(cand.entry_total) * PROD_W'(list_cnt[i]);
                theirs    = PROD_W'(list_tot[i]) * PROD_W'(cand.entry_count);
                move_down = (mine > theirs);
            end
            if (!move_down)
                break;
            if (i > 0)
            begin
                list_key[i-1] = list_key[i];
                list_cnt[i-1] = list_cnt[i];
                list_tot[i-1] = list_tot[i];
            end
            list_key[i] = cand.entry_key;
            list_cnt[i] = cand.entry_count;
            list_tot[i] = cand.entry_total;
        end
    endtask

    function automatic rsp_t slot_contents(input logic [SIDX_W-1:0] idx);
        rsp_t r;
        r = '0;
        if (int'(idx) < TOP_N)
        begin
            r.slot_key   = list_key[idx];
            r.slot_count = list_cnt[idx];
            r.slot_total = list_tot[idx];
            r.slot_used  = (list_cnt[idx] != '0);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TOP_N; i++)
            begin
                list_key[i] = '0;
                list_cnt[i] = '0;
                list_tot[i] = '0;
            end
            read_queue.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (read_queue.size() == 0)
                    report_mismatch("unexpected response beat", rsp_data.slot_key, '0);
                else
                begin
                    want = read_queue.pop_front();
                    if (rsp_data.slot_key !== want.slot_key)
                        report_mismatch("slot_key", rsp_data.slot_key, want.slot_key);
                    if (rsp_data.slot_count !== want.slot_count)
                        report_mismatch("slot_count", KEY_W'(rsp_data.slot_count),
                                        KEY_W'(want.slot_count));
                    if (rsp_data.slot_total !== want.slot_total)
                        report_mismatch("slot_total", KEY_W'(rsp_data.slot_total),
                                        KEY_W'(want.slot_total));
                    if (rsp_data.slot_used !== want.slot_used)
                        report_mismatch("slot_used", KEY_W'(rsp_data.slot_used),
                                        KEY_W'(want.slot_used));
                end
            end
            if (req_valid && !req_stall)
            begin
                if (req_data.op == OP_READ)
                    read_queue.push_back(slot_contents(req_data.slot_index));
                else
                    walk_candidate(req_data);
            end
        end
        fail_count    <= fail_tally;
        reads_waiting <= read_queue.size();
    end

endmodule

FILE: sim/top_k_average_insert_top_tb.sv
// ============================================================================
// top_k_average_insert_top_tb: regression bench for the top-k rating list
// Drives insert and read beats into the block with random gaps, stalls the
// response channel at random and once for a long stretch, and lets the
// checker module predict every read. Prints the verdict at the end.
// ============================================================================
module top_k_average_insert_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tkai_pkg::*;

    localparam int  RANDOM_BEATS = 1800;
    localparam int  POOL_N       = 24;          // more keys than slots, so slots get dropped
    localparam int  HOLD_CYCLES  = 300;         // long response hold-off
    localparam int  HOLD_AFTER   = 300;         // start the hold-off after this many beats
    localparam int  TAIL_CYCLES  = 2*TOP_N + 8; // longest insert walk plus margin
    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [KEY_W-1:0] KEY_B    = 64'h0123_4567_89AB_CDEF;
    localparam logic [KEY_W-1:0] KEY_C    = 64'hFEDC_BA98_7654_3210;
    localparam logic [KEY_W-1:0] KEY_D    = 64'h8000_0000_0000_0001;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    int fail_count;
    int reads_waiting;
    int beats_sent = 0;
    int cycle_cnt  = 0;

    logic [KEY_W-1:0] key_pool [POOL_N];

    // response-side idling state
    logic rsp_hold  = 1'b0;
    logic stall_on  = 1'b0;
    int   stall_run = 0;
    int   stall_roll;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    top_k_average_insert_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    tkai_list_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_data      (rsp_data),
        .fail_count    (fail_count),
        .reads_waiting (reads_waiting)
    );

    // Build an insert beat; slot_index is don't-care for inserts, so fill it.
    function automatic req_t insert_beat(input logic [KEY_W-1:0] key, input int unsigned cnt,
                                         input int unsigned tot);
        req_t b;
        b             = '0;
        b.op          = OP_INSERT;
        b.entry_key   = key;
        b.entry_count = COUNT_W'(cnt);
        b.entry_total = TOTAL_W'(tot);
        b.slot_index  = SIDX_W'($urandom());
        return b;
    endfunction

    // Build a read beat; candidate fields carry noise the block must ignore.
    function automatic req_t read_beat(input int unsigned idx);
        req_t b;
        b             = '0;
        b.op          = OP_READ;
        b.entry_key   = {$urandom(), $urandom()};
        b.entry_count = COUNT_W'($urandom());
        b.entry_total = TOTAL_W'($urandom_range(0, 327675));
        b.slot_index  = SIDX_W'(idx);
        return b;
    endfunction

    // Random beat: mostly inserts from a key pool with realistic averages,
    // a share of exact ties, empty candidates and full-range values.
    function automatic req_t random_beat();
        logic [KEY_W-1:0] key;
        int unsigned      pick;
        int unsigned      cnt;
        int unsigned      tot;
        if ($urandom_range(0, 99) < 30)
            return read_beat($urandom_range(0, TOP_N - 1));
        if ($urandom_range(0, 9) == 0)
            key = {$urandom(), $urandom()};
        else
            key = key_pool[$urandom_range(0, POOL_N - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            // empty candidate: must leave the list untouched
            cnt = 0;
            tot = $urandom_range(0, 327675);
        end
        else if (pick < 11)
        begin
            cnt = 65535;
            tot = $urandom_range(0, 327675);
        end
        else if (pick < 16)
        begin
            cnt = $urandom_range(1, 65535);
            tot = $urandom_range(0, 327675);
        end
        else if (pick < 40)
        begin
            // whole-star averages collide often and stop the walk on ties
            cnt = $urandom_range(1, 8);
            tot = cnt * $urandom_range(0, 5);
        end
        else
        begin
            cnt = $urandom_range(1, 60);
            tot = $urandom_range(0, 5 * cnt);
        end
        return insert_beat(key, cnt, tot);
    endfunction

    // Offer one beat, hold it until taken, then maybe drop valid for a gap.
    task automatic send_beat(input req_t b);
        int unsigned roll;
        int unsigned gap;
        req_valid <= 1'b1;
        req_data  <= b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        beats_sent++;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            gap = 0;
        else if (roll < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Response side: alternate runs of no stall, short random stalls and
    // long stalls; the hold-off flag overrides everything.
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 40)
            begin
                stall_on  = 1'b0;
                stall_run = $urandom_range(1, 40);
            end
            else if (stall_roll < 92)
            begin
                stall_on  = 1'($urandom_range(0, 1));
                stall_run = $urandom_range(1, 3);
            end
            else
            begin
                stall_on  = 1'b1;
                stall_run = $urandom_range(10, 40);
            end
        end
        stall_run--;
        rsp_stall <= rsp_hold | stall_on;
    end

    // Hold off the response channel for a long stretch while requests keep
    // coming, so the output register fills and the block stalls reads.
    initial
    begin
        wait (beats_sent >= HOLD_AFTER);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < POOL_N; i++)
            key_pool[i] = {$urandom(), $urandom()};
        key_pool[0] = '0;
        key_pool[1] = KEY_ONES;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Read both ends of the empty list first.
        send_beat(read_beat(0));
        send_beat(read_beat(TOP_N - 1));
        // Empty candidate with full-scale fields: nothing may change.
        send_beat(insert_beat(KEY_ONES, 0, 327675));
        // Largest count and total, then a zero average with key zero.
        send_beat(insert_beat(64'h1, 65535, 327675));
        send_beat(insert_beat('0, 1, 0));
        // Average 3, then an equal average that must stop below it.
        send_beat(insert_beat(KEY_B, 2, 6));
        send_beat(insert_beat(KEY_C, 1, 3));
        // Same key again with a higher average: it shifts up to its old
        // slot, overwrites that slot in place and leaves a duplicate below.
        send_beat(insert_beat(KEY_B, 4, 20));
        send_beat(insert_beat(KEY_ONES, 3, 7));
        // Highest possible average climbs to the top slot.
        send_beat(insert_beat(KEY_D, 1, 327675));
        for (int i = TOP_N - 7; i < TOP_N; i++)
            send_beat(read_beat(i));
        send_beat(read_beat(0));

        // Random part.
        for (int n = 0; n < RANDOM_BEATS; n++)
            send_beat(random_beat());

        // Drain: let the last read land, then wait out any insert still walking.
        req_valid <= 1'b0;
        @(posedge clk);
        while (reads_waiting != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && reads_waiting == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
